### src/offset_point_pi_tracking_controller_assert.svh
// assertion macros for the offset-point tracking controller
// used by the top level; expects clk_i and rst_ni in the including scope
`ifndef OFFSET_POINT_PI_TRACKING_CONTROLLER_ASSERT_SVH
`define OFFSET_POINT_PI_TRACKING_CONTROLLER_ASSERT_SVH
`ifndef SYNTH
`define OPPTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("opptc assertion failed");
`define OPPTC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("opptc forbidden condition");
`else
`define OPPTC_ASSERT(lbl, prop)
`define OPPTC_NEVER(lbl, expr)
`endif
`endif

### src/opptc_pkg.sv
// shared types, constants and helpers of the offset-point tracking controller
// no dependencies
package opptc_pkg;

  localparam int WORD_BITS    = 24;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int CSTEP_BITS   = $clog2(CORDIC_STEPS);
  localparam int CFG_BITS     = 23;
  localparam int WRAP_BITS    = WORD_BITS + 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WRAP_BITS-1:0] wide_t;

  // angle and gain constants, Q8.16
  localparam word_t PI_Q      = 24'sd205887;
  localparam word_t HALF_PI_Q = 24'sd102943;
  localparam word_t KGAIN_Q   = 24'sd39797;
  localparam wide_t TWO_PI_W  = 27'sd411774;
  localparam wide_t PI_W      = 27'sd205887;
  localparam word_t POS_RESET = -24'sd6554;

  localparam logic [15:0] ATAN_LUT [CORDIC_STEPS] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

  // register map
  typedef enum logic [2:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_OFFSET_D  = 3'd2,
    CFG_INV_OFF   = 3'd3,
    CFG_PERIOD    = 3'd4,
    CFG_VEL_LIM   = 3'd5,
    CFG_TURN_LIM  = 3'd6,
    CFG_NONE      = 3'd7
  } cfg_idx_e;

  localparam logic [CFG_BITS-1:0] RST_GAIN_P   = 23'd327680;
  localparam logic [CFG_BITS-1:0] RST_GAIN_I   = 23'd131072;
  localparam logic [CFG_BITS-1:0] RST_OFFSET_D = 23'd13107;
  localparam logic [CFG_BITS-1:0] RST_INV_OFF  = 23'd327680;
  localparam logic [15:0]         RST_PERIOD   = 16'd1311;
  localparam logic [CFG_BITS-1:0] RST_VEL_LIM  = 23'd98304;
  localparam logic [CFG_BITS-1:0] RST_TURN_LIM = 23'd65536;

  // multiply sequence, one shared multiplier
  typedef enum logic [4:0] {
    OP_HEAD, OP_WD, OP_VC, OP_WDS, OP_VS, OP_WDC, OP_DXT, OP_DYT, OP_EXT, OP_EYT,
    OP_PEX, OP_IEX, OP_PEY, OP_IEY, OP_CU1, OP_SU2, OP_CU2, OP_SU1, OP_WC
  } op_e;

  // saturate a one-bit-grown sum to the word range
  function automatic word_t sat_word(input logic signed [WORD_BITS:0] v);
    logic signed [WORD_BITS:0] hi;
    logic signed [WORD_BITS:0] lo;
    hi = (WORD_BITS+1)'((1 <<< (WORD_BITS-1)) - 1);
    lo = -hi - (WORD_BITS+1)'(1);
    if (v > hi) return hi[WORD_BITS-1:0];
    else if (v < lo) return lo[WORD_BITS-1:0];
    else return v[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    return sat_word({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    return sat_word({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
  endfunction

  // symmetric clamp against an unsigned limit
  function automatic word_t clamp_sym(input word_t v, input logic [CFG_BITS-1:0] lim);
    logic signed [WORD_BITS:0] l;
    logic signed [WORD_BITS:0] nl;
    logic signed [WORD_BITS:0] x;
    l  = {2'b00, lim};
    nl = -l;
    x  = {v[WORD_BITS-1], v};
    if (x > l) return l[WORD_BITS-1:0];
    else if (x < nl) return nl[WORD_BITS-1:0];
    else return v;
  endfunction

endpackage

### src/opptc_if.sv
// valid/ready channel interfaces for input and result transfers
// depends on opptc_pkg
interface opptc_in_if;
  import opptc_pkg::*;
  logic  valid;
  logic  ready;
  word_t lin_vel;
  word_t ang_vel;
  word_t ref_x;
  word_t ref_y;
  modport source (output valid, lin_vel, ang_vel, ref_x, ref_y, input ready);
  modport sink (input valid, lin_vel, ang_vel, ref_x, ref_y, output ready);
endinterface

interface opptc_out_if;
  import opptc_pkg::*;
  logic              valid;
  logic              ready;
  word_t             vel_cmd;
  word_t             turn_cmd;
  word_t             pos_x;
  word_t             pos_y;
  logic signed [18:0] heading;
  word_t             err_x;
  word_t             err_y;
  modport source (output valid, vel_cmd, turn_cmd, pos_x, pos_y, heading, err_x, err_y,
                  input ready);
  modport sink (input valid, vel_cmd, turn_cmd, pos_x, pos_y, heading, err_x, err_y,
                output ready);
endinterface

### src/opptc_qmul.sv
// shared fixed-point multiplier: truncate magnitude toward zero, saturate, register
// depends on opptc_pkg
module opptc_qmul import opptc_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t a_i,
  input  word_t b_i,
  output word_t prod_o
);

  logic [WORD_BITS-1:0]     mag_a;
  logic [WORD_BITS-1:0]     mag_b;
  logic [2*WORD_BITS-1:0]   full;
  logic [2*WORD_BITS-FRAC_BITS-1:0] shr;
  logic [2*WORD_BITS-FRAC_BITS-1:0] lim;
  logic                     neg;
  logic [WORD_BITS-1:0]     mag_r;
  word_t                    prod_q;

  // sign-magnitude product
  always_comb begin
    mag_a = a_i[WORD_BITS-1] ? WORD_BITS'(-a_i) : WORD_BITS'(a_i);
    mag_b = b_i[WORD_BITS-1] ? WORD_BITS'(-b_i) : WORD_BITS'(b_i);
    neg   = a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
    full  = mag_a * mag_b;
    shr   = full[2*WORD_BITS-1:FRAC_BITS];
    lim   = (2*WORD_BITS-FRAC_BITS)'({1'b0, {(WORD_BITS-1){1'b1}}}) +
            (2*WORD_BITS-FRAC_BITS)'(neg);
    mag_r = (shr > lim) ? lim[WORD_BITS-1:0] : shr[WORD_BITS-1:0];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= neg ? word_t'(-mag_r) : word_t'(mag_r);
    end
  end

  assign prod_o = prod_q;

endmodule

### src/offset_point_pi_tracking_controller.sv
// top level of the offset-point PI tracking controller
// depends on opptc_pkg, opptc_if, opptc_qmul and the assertion header
//
//   channel  dir  handshake              payload
//   in_i     in   valid/ready            lin_vel ang_vel ref_x ref_y
//   out_o    out  valid/ready            vel_cmd turn_cmd pos_x pos_y heading err_x err_y
//   apb      in   psel/penable, pready=1 7 config registers at 4*i
//
// an item runs 19 products through the one shared multiplier, 16 cordic
// steps, and a wrap step for each 2*pi taken off the heading
// reset returns to idle, clears the heading and error sums, sets the
// position to POS_RESET and restores register defaults; no clearing pass
// in_i.ready is high only while idle; a finished result waits in the output
// register, so the next item may be taken before it is read
`include "offset_point_pi_tracking_controller_assert.svh"
module offset_point_pi_tracking_controller import opptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  opptc_in_if.sink    in_i,
  opptc_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_WRAP = 5'b00100,
    ST_CORD = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q;
  op_e    op_q;
  logic   ph_q;

  logic [CFG_BITS-1:0] gain_p_q, gain_i_q, offset_d_q, inv_off_q, vel_lim_q, turn_lim_q;
  logic [15:0]         period_q;

  word_t v_q, w_q, rx_q, ry_q;
  word_t heading_q, pos_x_q, pos_y_q, exs_q, eys_q;
  word_t sin_q, cos_q, wd_q, dx_q, dy_q, ex_q, ey_q, u1_q, u2_q, acc_q, vc_q, wc_q;
  wide_t t_q;
  word_t x_q, y_q, z_q;
  logic  flip_q;
  logic [CSTEP_BITS-1:0] cnt_q;

  logic  out_valid_q;
  word_t o_vel_q, o_turn_q, o_px_q, o_py_q, o_ex_q, o_ey_q;
  logic signed [18:0] o_head_q;

  word_t mul_a, mul_b, prod;
  logic  mul_en;
  word_t period_w;
  wide_t head_w;
  word_t head_new;
  cfg_idx_e widx;
  cfg_idx_e ridx;

  assign pready   = 1'b1;
  assign period_w = word_t'({8'd0, period_q});
  assign widx     = cfg_idx_e'(paddr[4:2]);
  assign ridx     = cfg_idx_e'(paddr[4:2]);

  // register read mux
  always_comb begin
    unique case (ridx)
      CFG_GAIN_P:   prdata = 32'(gain_p_q);
      CFG_GAIN_I:   prdata = 32'(gain_i_q);
      CFG_OFFSET_D: prdata = 32'(offset_d_q);
      CFG_INV_OFF:  prdata = 32'(inv_off_q);
      CFG_PERIOD:   prdata = 32'(period_q);
      CFG_VEL_LIM:  prdata = 32'(vel_lim_q);
      CFG_TURN_LIM: prdata = 32'(turn_lim_q);
      default:      prdata = 32'd0;
    endcase
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= RST_GAIN_P;
      gain_i_q   <= RST_GAIN_I;
      offset_d_q <= RST_OFFSET_D;
      inv_off_q  <= RST_INV_OFF;
      period_q   <= RST_PERIOD;
      vel_lim_q  <= RST_VEL_LIM;
      turn_lim_q <= RST_TURN_LIM;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        CFG_GAIN_P:   gain_p_q   <= pwdata[CFG_BITS-1:0];
        CFG_GAIN_I:   gain_i_q   <= pwdata[CFG_BITS-1:0];
        CFG_OFFSET_D: offset_d_q <= pwdata[CFG_BITS-1:0];
        CFG_INV_OFF:  inv_off_q  <= pwdata[CFG_BITS-1:0];
        CFG_PERIOD:   period_q   <= pwdata[15:0];
        CFG_VEL_LIM:  vel_lim_q  <= pwdata[CFG_BITS-1:0];
        CFG_TURN_LIM: turn_lim_q <= pwdata[CFG_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (op_q)
      OP_HEAD: begin mul_a = w_q;   mul_b = period_w; end
      OP_WD:   begin mul_a = w_q;   mul_b = word_t'({1'b0, offset_d_q}); end
      OP_VC:   begin mul_a = v_q;   mul_b = cos_q; end
      OP_WDS:  begin mul_a = wd_q;  mul_b = sin_q; end
      OP_VS:   begin mul_a = v_q;   mul_b = sin_q; end
      OP_WDC:  begin mul_a = wd_q;  mul_b = cos_q; end
      OP_DXT:  begin mul_a = dx_q;  mul_b = period_w; end
      OP_DYT:  begin mul_a = dy_q;  mul_b = period_w; end
      OP_EXT:  begin mul_a = ex_q;  mul_b = period_w; end
      OP_EYT:  begin mul_a = ey_q;  mul_b = period_w; end
      OP_PEX:  begin mul_a = word_t'({1'b0, gain_p_q}); mul_b = ex_q; end
      OP_IEX:  begin mul_a = word_t'({1'b0, gain_i_q}); mul_b = exs_q; end
      OP_PEY:  begin mul_a = word_t'({1'b0, gain_p_q}); mul_b = ey_q; end
      OP_IEY:  begin mul_a = word_t'({1'b0, gain_i_q}); mul_b = eys_q; end
      OP_CU1:  begin mul_a = cos_q; mul_b = u1_q; end
      OP_SU2:  begin mul_a = sin_q; mul_b = u2_q; end
      OP_CU2:  begin mul_a = cos_q; mul_b = u2_q; end
      OP_SU1:  begin mul_a = sin_q; mul_b = u1_q; end
      OP_WC:   begin mul_a = word_t'({1'b0, inv_off_q}); mul_b = acc_q; end
      default: begin mul_a = '0;    mul_b = '0; end
    endcase
  end

  assign mul_en = (state_q == ST_MAC) && !ph_q;

  opptc_qmul u_qmul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // heading candidate once the wrap has settled
  assign head_w   = t_q - PI_W;
  assign head_new = head_w[WORD_BITS-1:0];

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_HEAD;
      ph_q        <= 1'b0;
      cnt_q       <= '0;
      heading_q   <= '0;
      pos_x_q     <= POS_RESET;
      pos_y_q     <= POS_RESET;
      exs_q       <= '0;
      eys_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result register fills from the done state, empties on a transfer
      if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            v_q     <= in_i.lin_vel;
            w_q     <= in_i.ang_vel;
            rx_q    <= in_i.ref_x;
            ry_q    <= in_i.ref_y;
            op_q    <= OP_HEAD;
            ph_q    <= 1'b0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            op_q <= (op_q == OP_WC) ? OP_HEAD : op_e'(op_q + 5'd1);
            unique case (op_q)
              OP_HEAD: begin
                t_q     <= wide_t'(heading_q) + wide_t'(prod) + PI_W;
                state_q <= ST_WRAP;
              end
              OP_WD:  wd_q  <= prod;
              OP_VC:  acc_q <= prod;
              OP_WDS: dx_q  <= sat_sub(acc_q, prod);
              OP_VS:  acc_q <= prod;
              OP_WDC: dy_q  <= sat_add(acc_q, prod);
              OP_DXT: pos_x_q <= sat_add(pos_x_q, prod);
              OP_DYT: begin
                pos_y_q <= sat_add(pos_y_q, prod);
                ex_q    <= sat_sub(rx_q, pos_x_q);
              end
              OP_EXT: begin
                exs_q <= sat_add(exs_q, prod);
                ey_q  <= sat_sub(ry_q, pos_y_q);
              end
              OP_EYT: eys_q <= sat_add(eys_q, prod);
              OP_PEX: acc_q <= prod;
              OP_IEX: u1_q  <= sat_add(acc_q, prod);
              OP_PEY: acc_q <= prod;
              OP_IEY: u2_q  <= sat_add(acc_q, prod);
              OP_CU1: acc_q <= prod;
              OP_SU2: vc_q  <= clamp_sym(sat_add(acc_q, prod), vel_lim_q);
              OP_CU2: acc_q <= prod;
              OP_SU1: acc_q <= sat_sub(acc_q, prod);
              OP_WC: begin
                wc_q    <= clamp_sym(prod, turn_lim_q);
                state_q <= ST_DONE;
              end
              default: ;
            endcase
          end
        end
        ST_WRAP: begin
          // one period of 2*pi per cycle, then seed the rotation
          priority if (t_q >= TWO_PI_W) begin
            t_q <= t_q - TWO_PI_W;
          end else if (t_q < 0) begin
            t_q <= t_q + TWO_PI_W;
          end else begin
            heading_q <= head_new;
            x_q       <= KGAIN_Q;
            y_q       <= '0;
            cnt_q     <= '0;
            state_q   <= ST_CORD;
            priority if (head_new > HALF_PI_Q) begin
              z_q    <= head_new - PI_Q;
              flip_q <= 1'b1;
            end else if (head_new < -HALF_PI_Q) begin
              z_q    <= head_new + PI_Q;
              flip_q <= 1'b1;
            end else begin
              z_q    <= head_new;
              flip_q <= 1'b0;
            end
          end
        end
        ST_CORD: begin
          // one rotation step per cycle
          if (!z_q[WORD_BITS-1]) begin
            x_q <= x_q - (y_q >>> cnt_q);
            y_q <= y_q + (x_q >>> cnt_q);
            z_q <= z_q - word_t'({8'd0, ATAN_LUT[cnt_q]});
          end else begin
            x_q <= x_q + (y_q >>> cnt_q);
            y_q <= y_q - (x_q >>> cnt_q);
            z_q <= z_q + word_t'({8'd0, ATAN_LUT[cnt_q]});
          end
          cnt_q <= cnt_q + CSTEP_BITS'(1);
          if (cnt_q == CSTEP_BITS'(CORDIC_STEPS - 1)) begin
            state_q <= ST_MAC;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            o_vel_q     <= vc_q;
            o_turn_q    <= wc_q;
            o_px_q      <= pos_x_q;
            o_py_q      <= pos_y_q;
            o_head_q    <= heading_q[18:0];
            o_ex_q      <= ex_q;
            o_ey_q      <= ey_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // finished sine and cosine, sign restored for the far half-plane
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CORD && cnt_q == CSTEP_BITS'(CORDIC_STEPS - 1)) begin
      sin_q <= flip_q ? -(y_q + (!z_q[WORD_BITS-1] ? (x_q >>> cnt_q) : -(x_q >>> cnt_q)))
                      :  (y_q + (!z_q[WORD_BITS-1] ? (x_q >>> cnt_q) : -(x_q >>> cnt_q)));
      cos_q <= flip_q ? -(x_q - (!z_q[WORD_BITS-1] ? (y_q >>> cnt_q) : -(y_q >>> cnt_q)))
                      :  (x_q - (!z_q[WORD_BITS-1] ? (y_q >>> cnt_q) : -(y_q >>> cnt_q)));
    end
  end

  // channel outputs
  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.vel_cmd  = o_vel_q;
  assign out_o.turn_cmd = o_turn_q;
  assign out_o.pos_x    = o_px_q;
  assign out_o.pos_y    = o_py_q;
  assign out_o.heading  = o_head_q;
  assign out_o.err_x    = o_ex_q;
  assign out_o.err_y    = o_ey_q;

  // checks
  `OPPTC_ASSERT(a_take_starts, (in_i.valid && in_i.ready) |=> (state_q == ST_MAC))
  `OPPTC_NEVER(a_head_range, (heading_q < -PI_Q) || (heading_q >= PI_Q))
  `OPPTC_ASSERT(a_result_kept, (out_valid_q && !out_o.ready) |=> out_valid_q)
  `OPPTC_ASSERT(a_done_loads, (state_q == ST_DONE && !out_valid_q) |=> out_valid_q)
  `OPPTC_ASSERT(a_state_onehot, $onehot(state_q))

endmodule
